### src/srle_pkg.sv
package srle_pkg;

  localparam int PIX_W         = 8;
  localparam int CFG_W         = 12;
  localparam int CLEAR_W       = 11;
  localparam int OPQ_W         = 8;
  localparam int DEF_MAX_WIDTH = 2048;

  localparam logic [PIX_W-1:0]   END_CODE    = 8'd255;
  localparam logic [PIX_W-1:0]   OPAQUE_CAP  = 8'd255;
  localparam logic [PIX_W-1:0]   ZERO_CODE   = 8'd0;
  localparam logic [CLEAR_W-1:0] CLEAR_SPLIT = 11'd254;
  localparam logic [CLEAR_W-1:0] CLEAR_SAT   = 11'd2047;

  localparam logic KIND_CODE  = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  // one datapath operation per cycle, issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_SPLIT_HI,
    OP_SPLIT_LO,
    OP_CLEAR,
    OP_CAP_HI,
    OP_CAP_LO,
    OP_PIXEL,
    OP_RUN_END,
    OP_ROW_COUNT,
    OP_ROW_END
  } op_e;

  typedef struct packed {
    op_e  op;
    logic last;
  } srle_cmd_t;

  typedef struct packed {
    logic px_zero;    // incoming pixel is transparent
    logic in_run;     // an opaque run is open
    logic cap;        // opaque run has reached its cap
    logic clear_big;  // pending clear run needs splitting
    logic rem_big;    // remaining clear count still needs splitting
    logic row_now;    // incoming pixel closes the row
    logic row_q;      // word being worked on closes the row
    logic emit_ok;    // output register can take a word
  } srle_status_t;

endpackage

### src/srle_ctrl.sv
module srle_ctrl
  import srle_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         pixel_valid_i,
  output logic         pixel_ready_o,
  input  srle_status_t status_i,
  output srle_cmd_t    cmd_o
);

  typedef enum logic [9:0] {
    ST_IDLE      = 10'b00_0000_0001,
    ST_SPLIT_HI  = 10'b00_0000_0010,
    ST_SPLIT_LO  = 10'b00_0000_0100,
    ST_CLEAR     = 10'b00_0000_1000,
    ST_CAP_HI    = 10'b00_0001_0000,
    ST_CAP_LO    = 10'b00_0010_0000,
    ST_PIXEL     = 10'b00_0100_0000,
    ST_RUN_END   = 10'b00_1000_0000,
    ST_ROW_COUNT = 10'b01_0000_0000,
    ST_ROW_END   = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  assign pixel_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d   = state_q;
    cmd_o.op   = OP_NONE;
    cmd_o.last = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (pixel_valid_i) begin
          cmd_o.op = OP_ACCEPT;
          if (status_i.px_zero) begin
            if (status_i.in_run) begin
              state_d = ST_RUN_END;
            end else if (status_i.row_now) begin
              state_d = ST_ROW_END;
            end
          end else if (status_i.in_run) begin
            state_d = status_i.cap ? ST_CAP_HI : ST_PIXEL;
          end else begin
            state_d = status_i.clear_big ? ST_SPLIT_HI : ST_CLEAR;
          end
        end
      end
      ST_SPLIT_HI: begin
        if (status_i.emit_ok) begin
          cmd_o.op = OP_SPLIT_HI;
          state_d  = ST_SPLIT_LO;
        end
      end
      ST_SPLIT_LO: begin
        if (status_i.emit_ok) begin
          cmd_o.op = OP_SPLIT_LO;
          state_d  = status_i.rem_big ? ST_SPLIT_HI : ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        if (status_i.emit_ok) begin
          cmd_o.op = OP_CLEAR;
          state_d  = ST_PIXEL;
        end
      end
      ST_CAP_HI: begin
        if (status_i.emit_ok) begin
          cmd_o.op = OP_CAP_HI;
          state_d  = ST_CAP_LO;
        end
      end
      ST_CAP_LO: begin
        if (status_i.emit_ok) begin
          cmd_o.op = OP_CAP_LO;
          state_d  = ST_PIXEL;
        end
      end
      ST_PIXEL: begin
        if (status_i.emit_ok) begin
          cmd_o.op   = OP_PIXEL;
          cmd_o.last = !status_i.row_q;
          state_d    = status_i.row_q ? ST_ROW_COUNT : ST_IDLE;
        end
      end
      ST_RUN_END: begin
        if (status_i.emit_ok) begin
          cmd_o.op   = OP_RUN_END;
          cmd_o.last = !status_i.row_q;
          state_d    = status_i.row_q ? ST_ROW_END : ST_IDLE;
        end
      end
      ST_ROW_COUNT: begin
        if (status_i.emit_ok) begin
          cmd_o.op = OP_ROW_COUNT;
          state_d  = ST_ROW_END;
        end
      end
      ST_ROW_END: begin
        if (status_i.emit_ok) begin
          cmd_o.op   = OP_ROW_END;
          cmd_o.last = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### src/srle_dpath.sv
module srle_dpath
  import srle_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CFG_W-1:0]   cfg_wdata_i,
  input  logic [PIX_W-1:0]   pixel_i,
  input  srle_cmd_t          cmd_i,
  output srle_status_t       status_o,
  output logic               result_valid_o,
  input  logic               result_ready_i,
  output logic               kind_o,
  output logic [PIX_W-1:0]   value_o,
  output logic               last_o
);

  localparam int CLW = $clog2(MAX_WIDTH);
  localparam int WW  = (CLW + 1 > CFG_W) ? CLW + 1 : CFG_W;

  logic [CFG_W-1:0]   line_width_q;
  logic [CLW-1:0]     column_q;
  logic [CLEAR_W-1:0] clear_count_q;
  logic [CLEAR_W-1:0] rem_q;
  logic [OPQ_W-1:0]   opaque_count_q;
  logic               in_run_q;
  logic [PIX_W-1:0]   pixel_q;
  logic               row_q;

  logic               out_valid_q;
  logic               kind_q;
  logic [PIX_W-1:0]   value_q;
  logic               last_q;

  logic [WW-1:0]      lw_ext, eff_width, col_inc;
  logic               row_now, emit_ok, emit;
  logic               kind_d;
  logic [PIX_W-1:0]   value_d;

  // effective width: zero acts as one, clamp to the largest row
  assign lw_ext    = WW'(line_width_q);
  assign eff_width = (lw_ext == '0) ? WW'(1) :
                     ((lw_ext > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : lw_ext);
  assign col_inc   = WW'(column_q) + WW'(1);
  assign row_now   = (col_inc >= eff_width);

  assign emit_ok = !out_valid_q || result_ready_i;
  assign emit    = (cmd_i.op != OP_NONE) && (cmd_i.op != OP_ACCEPT);

  assign status_o.px_zero   = (pixel_i == '0);
  assign status_o.in_run    = in_run_q;
  assign status_o.cap       = (opaque_count_q == OPAQUE_CAP);
  assign status_o.clear_big = (clear_count_q > CLEAR_SPLIT);
  assign status_o.rem_big   = (rem_q > CLEAR_SPLIT);
  assign status_o.row_now   = row_now;
  assign status_o.row_q     = row_q;
  assign status_o.emit_ok   = emit_ok;

  always_comb begin
    kind_d  = KIND_CODE;
    value_d = ZERO_CODE;
    unique case (cmd_i.op)
      OP_SPLIT_HI:  value_d = PIX_W'(CLEAR_SPLIT);
      OP_CLEAR:     value_d = PIX_W'(rem_q);
      OP_CAP_HI:    value_d = OPAQUE_CAP;
      OP_PIXEL: begin
        kind_d  = KIND_PIXEL;
        value_d = pixel_q;
      end
      OP_RUN_END,
      OP_ROW_COUNT: value_d = opaque_count_q;
      OP_ROW_END:   value_d = END_CODE;
      default:      value_d = ZERO_CODE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q   <= CFG_W'(1);
      column_q       <= '0;
      clear_count_q  <= '0;
      opaque_count_q <= '0;
      in_run_q       <= 1'b0;
      row_q          <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        line_width_q <= cfg_wdata_i;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (result_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (cmd_i.op)
        OP_ACCEPT: begin
          row_q    <= row_now;
          column_q <= row_now ? '0 : column_q + CLW'(1);
          if ((pixel_i == '0) && !in_run_q && (clear_count_q != CLEAR_SAT)) begin
            clear_count_q <= clear_count_q + CLEAR_W'(1);
          end
        end
        OP_CLEAR: begin
          clear_count_q  <= '0;
          in_run_q       <= 1'b1;
          opaque_count_q <= '0;
        end
        OP_CAP_HI: begin
          opaque_count_q <= '0;
        end
        OP_PIXEL: begin
          opaque_count_q <= opaque_count_q + OPQ_W'(1);
        end
        OP_RUN_END: begin
          // this transparent pixel opens the next clear run
          in_run_q       <= 1'b0;
          opaque_count_q <= '0;
          clear_count_q  <= CLEAR_W'(1);
        end
        OP_ROW_END: begin
          in_run_q       <= 1'b0;
          opaque_count_q <= '0;
          clear_count_q  <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_ACCEPT) begin
      pixel_q <= pixel_i;
      rem_q   <= clear_count_q;
    end else if (cmd_i.op == OP_SPLIT_HI) begin
      rem_q <= rem_q - CLEAR_SPLIT;
    end
    if (emit) begin
      kind_q  <= kind_d;
      value_q <= value_d;
      last_q  <= cmd_i.last;
    end
  end

  assign result_valid_o = out_valid_q;
  assign kind_o         = kind_q;
  assign value_o        = value_q;
  assign last_o         = last_q;

  a_emit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> emit_ok)
    else $error("word emitted while output register is occupied");

  a_run_no_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_run_q |-> (clear_count_q == '0))
    else $error("clear count pending inside an opaque run");

  a_row_end_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_ROW_END) |=> (column_q == '0) && !in_run_q && (opaque_count_q == '0))
    else $error("row state not cleared at end of row");

  a_column_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    WW'(column_q) < WW'(MAX_WIDTH))
    else $error("column beyond largest row");

endmodule

### src/sprite_row_rle_encoder_unit.sv
// An accepted pixel sets the controller's next state, from which its first word enters the
// output register once it is free or being read; a stalled output holds the controller.
// A clear run of c pixels splits into 2*floor((c-1)/254) extra words.
// The controller works on one pixel at a time; the output register frees the input side.
// Reset: asynchronous, active low; line width returns to 1 and all run state clears.
module sprite_row_rle_encoder_unit
  import srle_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             pixel_valid_i,
  output logic             pixel_ready_o,
  input  logic [PIX_W-1:0] pixel_i,
  output logic             result_valid_o,
  input  logic             result_ready_i,
  output logic             kind_o,
  output logic [PIX_W-1:0] value_o,
  output logic             last_o
);

  srle_cmd_t    cmd;
  srle_status_t status;

  srle_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pixel_valid_i (pixel_valid_i),
    .pixel_ready_o (pixel_ready_o),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  srle_dpath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .pixel_i        (pixel_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .result_valid_o (result_valid_o),
    .result_ready_i (result_ready_i),
    .kind_o         (kind_o),
    .value_o        (value_o),
    .last_o         (last_o)
  );

endmodule

### tb/sv/tb_sprite_row_rle_encoder_unit.sv
module tb_sprite_row_rle_encoder_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import srle_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 32;
  localparam int MAX_REPORTS   = 20;
  localparam int RANDOM_CODED  = 40;

  typedef struct packed {
    logic             kind;
    logic [PIX_W-1:0] value;
    logic             last;
  } out_word_t;

  logic             clk_i          = 1'b0;
  logic             rst_ni         = 1'b0;
  logic             cfg_we_i       = 1'b0;
  logic [CFG_W-1:0] cfg_wdata_i    = '0;
  logic             pixel_valid_i  = 1'b0;
  logic [PIX_W-1:0] pixel_i        = '0;
  logic             result_ready_i = 1'b0;
  logic             pixel_ready_o;
  logic             result_valid_o;
  logic             kind_o;
  logic [PIX_W-1:0] value_o;
  logic             last_o;

  // encoder state as predicted
  logic [CFG_W-1:0]   enc_width;
  logic [CLEAR_W-1:0] enc_col;
  logic [CLEAR_W-1:0] enc_clear;
  logic [OPQ_W-1:0]   enc_opaque;
  logic               enc_in_run;

  out_word_t step_words [0:23];
  int        step_n;
  out_word_t expected_words [$];
  out_word_t want_word;

  int err_count    = 0;
  int coded_pixels = 0;
  int cycle_count  = 0;
  int hold_cycles  = 0;
  int rdy_stall    = 0;
  bit idle_on      = 1'b1;

  sprite_row_rle_encoder_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .pixel_valid_i  (pixel_valid_i),
    .pixel_ready_o  (pixel_ready_o),
    .pixel_i        (pixel_i),
    .result_valid_o (result_valid_o),
    .result_ready_i (result_ready_i),
    .kind_o         (kind_o),
    .value_o        (value_o),
    .last_o         (last_o)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("ERROR at %0t: %s", $time, msg);
  endtask

  function automatic int row_length(logic [CFG_W-1:0] w);
    if (w == '0) return 1;
    if (w > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
    return int'(w);
  endfunction

  function void add_word(logic kind, logic [PIX_W-1:0] value);
    step_words[step_n] = {kind, value, 1'b0};
    step_n++;
  endfunction

  // fill step_words with the words one pixel causes and advance the row state
  function void encode_pixel(logic [PIX_W-1:0] px);
    logic [CLEAR_W-1:0] rest;
    int                 next_col;
    step_n = 0;
    if (px == '0) begin
      if (enc_in_run) begin
        add_word(KIND_CODE, enc_opaque);
        enc_in_run = 1'b0;
        enc_opaque = '0;
        enc_clear  = '0;
      end
      if (enc_clear < CLEAR_SAT) enc_clear = enc_clear + 1'b1;
    end else begin
      if (enc_in_run) begin
        if (enc_opaque >= OPAQUE_CAP) begin
          add_word(KIND_CODE, OPAQUE_CAP);
          add_word(KIND_CODE, ZERO_CODE);
          enc_opaque = '0;
        end
      end else begin
        rest = enc_clear;
        while (rest > CLEAR_SPLIT) begin
          add_word(KIND_CODE, CLEAR_SPLIT[PIX_W-1:0]);
          add_word(KIND_CODE, ZERO_CODE);
          rest = rest - CLEAR_SPLIT;
        end
        add_word(KIND_CODE, rest[PIX_W-1:0]);
        enc_clear  = '0;
        enc_in_run = 1'b1;
        enc_opaque = '0;
      end
      enc_opaque = enc_opaque + 1'b1;
      add_word(KIND_PIXEL, px);
    end
    next_col = int'(enc_col) + 1;
    if (next_col >= row_length(enc_width)) begin
      if (enc_in_run) add_word(KIND_CODE, enc_opaque);
      add_word(KIND_CODE, END_CODE);
      next_col   = 0;
      enc_clear  = '0;
      enc_opaque = '0;
      enc_in_run = 1'b0;
    end
    enc_col = next_col[CLEAR_W-1:0];
    if (step_n > 0) step_words[step_n-1].last = 1'b1;
  endfunction

  task automatic send_pixel(input logic [PIX_W-1:0] px);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      pixel_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    pixel_valid_i <= 1'b1;
    pixel_i       <= px;
    @(posedge clk_i);
    while (!pixel_ready_o) @(posedge clk_i);
    encode_pixel(px);
    for (int k = 0; k < step_n; k++) expected_words.push_back(step_words[k]);
    if (step_n != 0) coded_pixels++;
  endtask

  // drop valid, let every expected word arrive, then let the block settle
  task automatic wait_idle();
    pixel_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_width(input logic [CFG_W-1:0] w);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    enc_width = w;
  endtask

  function automatic logic [PIX_W-1:0] pick_opaque();
    case ($urandom_range(0, 9))
      0: return 8'd1;
      1: return 8'd255;
      default: return PIX_W'($urandom_range(1, 255));
    endcase
  endfunction

  // alternate clear and opaque runs of random length
  task automatic send_runs(input int count, input bit long_clear);
    int  left;
    int  len;
    bit  clear_turn;
    left       = count;
    clear_turn = $urandom_range(0, 1);
    while (left > 0) begin
      if (clear_turn)
        len = (long_clear && $urandom_range(0, 2) == 0) ? $urandom_range(200, 600)
                                                        : $urandom_range(0, 5);
      else
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 20) : $urandom_range(1, 4);
      if (len > left) len = left;
      repeat (len) send_pixel(clear_turn ? 8'd0 : pick_opaque());
      left       = left - len;
      clear_turn = !clear_turn;
    end
  endtask

  task automatic send_noise(input int count);
    repeat (count) send_pixel($urandom_range(0, 1) ? 8'd0 : PIX_W'($urandom_range(0, 255)));
  endtask

  always @(posedge clk_i) begin
    if (hold_cycles != 0) hold_cycles <= hold_cycles - 1;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o && result_ready_i) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word kind %0d value %0d last %0d",
                                    kind_o, value_o, last_o));
        end else begin
          want_word = expected_words.pop_front();
          if (kind_o !== want_word.kind || value_o !== want_word.value ||
              last_o !== want_word.last)
            report_mismatch($sformatf("word kind %0d value %0d last %0d, want %0d %0d %0d",
                                      kind_o, value_o, last_o, want_word.kind,
                                      want_word.value, want_word.last));
        end
      end
      if (hold_cycles != 0) begin
        result_ready_i <= 1'b0;
      end else if (rdy_stall != 0) begin
        result_ready_i <= 1'b0;
        rdy_stall      <= rdy_stall - 1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        result_ready_i <= 1'b0;
        rdy_stall      <= $urandom_range(0, 9);
      end else begin
        result_ready_i <= 1'b1;
      end
    end
  end

  // width 1 after reset: every pixel closes its own row
  task automatic test_reset_width();
    idle_on = 1'b0;
    send_pixel(8'd0);
    send_pixel(8'd255);
    send_pixel(8'd1);
    idle_on = 1'b1;
  endtask

  task automatic test_width_limits();
    write_width('0);
    send_pixel(8'd128);
    // all ones clamps to the widest row, so a short row stays open
    write_width('1);
    send_pixel(8'd0);
    send_pixel(8'd0);
    send_pixel(8'h5A);
    send_pixel(8'hAA);
    // narrow the row below the open column: the next pixel closes it
    write_width(12'd2);
    send_pixel(8'd0);
  endtask

  task automatic test_clear_split();
    write_width(12'd258);
    repeat (255) send_pixel(8'd0);
    send_pixel(8'h80);
    send_pixel(8'h81);
    send_pixel(8'd0);
  endtask

  task automatic test_width_change();
    write_width(12'd8);
    send_pixel(8'd3);
    send_pixel(8'd0);
    send_pixel(8'd0);
    send_pixel(8'd7);
    send_pixel(8'd9);
    // column already past the new width: the next pixel closes the row
    write_width(12'd3);
    send_pixel(8'd0);
    send_pixel(8'd4);
    send_pixel(8'd0);
    write_width(12'd10);
    send_runs(8, 1'b0);
  endtask

  task automatic test_output_stall();
    write_width(12'd20);
    idle_on = 1'b0;
    hold_cycles <= 200;
    send_runs(30, 1'b0);
    idle_on = 1'b1;
  endtask

  task automatic test_random_rows();
    int start;
    int w;
    int len;
    start = coded_pixels;
    while (coded_pixels - start < RANDOM_CODED) begin
      idle_on = (coded_pixels - start < 25) && ($urandom_range(0, 4) != 0);
      case ($urandom_range(0, 9))
        0: w = 1;
        1: w = 0;
        default: w = $urandom_range(2, 12);
      endcase
      write_width(CFG_W'(w));
      len = row_length(enc_width);
      // finish a row left open by the previous phase
      if (enc_col != '0) send_runs((int'(enc_col) < len) ? len - int'(enc_col) : 1, len > 254);
      repeat ($urandom_range(1, 2)) begin
        if ($urandom_range(0, 4) == 0) send_noise(len);
        else send_runs(len, len > 254);
      end
      if ($urandom_range(0, 5) == 0) send_runs($urandom_range(1, len), 1'b0);
    end
  endtask

  initial begin
    enc_width  = 12'd1;
    enc_col    = '0;
    enc_clear  = '0;
    enc_opaque = '0;
    enc_in_run = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_width();
    test_width_limits();
    test_clear_split();
    test_width_change();
    test_output_stall();
    test_random_rows();

    idle_on = 1'b0;
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_words.size() != 0)
      report_mismatch($sformatf("%0d expected words never arrived", expected_words.size()));
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

### files.f
src/srle_pkg.sv
src/srle_ctrl.sv
src/srle_dpath.sv
src/sprite_row_rle_encoder_unit.sv
tb/sv/tb_sprite_row_rle_encoder_unit.sv
